// ===== hw/rtl/abtb_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, types and register codes for the transformed bounding box unit.
package abtb_pkg;

	// Coordinate and coefficient formats: signed Q16.16 and signed Q4.12.
	localparam int COORD_W    = 32;
	localparam int COEFF_W    = 16;
	localparam int COEFF_FRAC = COEFF_W - 4;
	localparam int RFRAC      = COEFF_FRAC + 1;

	// Extent and midpoint sums, products, product sums and final bounds.
	localparam int EXT_W  = COORD_W + 1;
	localparam int MAG_W  = COEFF_W + 1;
	localparam int PROD_W = EXT_W + MAG_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int ACC_W  = SUM_W + 1;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 3 * COEFF_W;

	// Unit coefficient, used for the identity map after reset.
	localparam logic [COEFF_W-1:0] COEFF_ONE = COEFF_W'(1) << COEFF_FRAC;

	// Ends of the coordinate range.
	localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FROM_X = 2'd0,
		REG_FROM_Y = 2'd1,
		REG_FROM_Z = 2'd2
	} cfg_reg_t;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [EXT_W-1:0]   ext_t;
	typedef logic        [COEFF_W-1:0] mag_t;
	typedef logic signed [PROD_W-1:0]  prod_t;

	typedef coord_t coord_arr_t [3];
	typedef ext_t   ext_arr_t   [3];
	// Indexed [source axis][output axis].
	typedef mag_t   mag_mat_t   [3][3];
	typedef prod_t  prod_mat_t  [3][3];

	// Load enables of the pipeline registers, one per stage.
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} stage_en_t;

endpackage

// ===== hw/rtl/abtb_coeff_regs.sv =====
`timescale 1ns / 1ps
// Coefficient registers, stored as magnitudes since only |m| enters the bounds.
module abtb_coeff_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [abtb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [abtb_pkg::CFG_DATA_W-1:0]  cfg_data,
	output abtb_pkg::mag_mat_t               mag
);

	abtb_pkg::mag_mat_t mag_q;

	// Two's complement magnitude; the most negative code maps to its unsigned value.
	function automatic abtb_pkg::mag_t coeff_mag(input logic [abtb_pkg::COEFF_W-1:0] f);
		return f[abtb_pkg::COEFF_W-1] ? (~f + abtb_pkg::COEFF_W'(1)) : f;
	endfunction

	assign cfg_ready = 1'b1;

	// A write replaces one source row; an index past the last register is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					mag_q[i][j] <= (i == j) ? abtb_pkg::COEFF_ONE : '0;
				end
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				abtb_pkg::REG_FROM_X: begin
					for (int j = 0; j < 3; j++) begin
						mag_q[0][j] <= coeff_mag(cfg_data[j*abtb_pkg::COEFF_W +: abtb_pkg::COEFF_W]);
					end
				end
				abtb_pkg::REG_FROM_Y: begin
					for (int j = 0; j < 3; j++) begin
						mag_q[1][j] <= coeff_mag(cfg_data[j*abtb_pkg::COEFF_W +: abtb_pkg::COEFF_W]);
					end
				end
				abtb_pkg::REG_FROM_Z: begin
					for (int j = 0; j < 3; j++) begin
						mag_q[2][j] <= coeff_mag(cfg_data[j*abtb_pkg::COEFF_W +: abtb_pkg::COEFF_W]);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign mag = mag_q;

endmodule

// ===== hw/rtl/abtb_extent_mult.sv =====
`timescale 1ns / 1ps
// Stages 1 and 2: box extents and corner sums, then the nine coefficient products.
module abtb_extent_mult (
	input  logic                   clk,
	input  abtb_pkg::stage_en_t    en,
	input  abtb_pkg::coord_arr_t   box_min,
	input  abtb_pkg::coord_arr_t   box_max,
	input  abtb_pkg::mag_mat_t     mag,
	output abtb_pkg::ext_arr_t     mid_s2,
	output abtb_pkg::prod_mat_t    prod_s2
);

	abtb_pkg::ext_arr_t ext_s1;
	abtb_pkg::ext_arr_t mid_s1;

	// Stage 1: extent max - min and corner sum max + min, both one bit wider.
	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			for (int i = 0; i < 3; i++) begin
				ext_s1[i] <= abtb_pkg::EXT_W'(box_max[i]) - abtb_pkg::EXT_W'(box_min[i]);
				mid_s1[i] <= abtb_pkg::EXT_W'(box_max[i]) + abtb_pkg::EXT_W'(box_min[i]);
			end
		end
	end

	// Stage 2: each source extent scaled by each coefficient magnitude.
	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			for (int i = 0; i < 3; i++) begin
				mid_s2[i] <= mid_s1[i];
				for (int j = 0; j < 3; j++) begin
					prod_s2[i][j] <= ext_s1[i] * $signed({1'b0, mag[i][j]});
				end
			end
		end
	end

endmodule

// ===== hw/rtl/abtb_bound_round.sv =====
`timescale 1ns / 1ps
// Stages 3 and 4: half-span sums, centre, rounding and saturation of each bound.
module abtb_bound_round (
	input  logic                   clk,
	input  abtb_pkg::stage_en_t    en,
	input  abtb_pkg::ext_arr_t     mid_s2,
	input  abtb_pkg::prod_mat_t    prod_s2,
	output abtb_pkg::coord_arr_t   new_min_s4,
	output abtb_pkg::coord_arr_t   new_max_s4,
	output logic                   sat_s4
);

	localparam logic signed [abtb_pkg::ACC_W-1:0] HALF_STEP =
		abtb_pkg::ACC_W'(1) << abtb_pkg::COEFF_FRAC;
	localparam logic signed [abtb_pkg::ACC_W-1:0] LIM_HI =
		abtb_pkg::ACC_W'($signed(abtb_pkg::COORD_MAX));
	localparam logic signed [abtb_pkg::ACC_W-1:0] LIM_LO =
		abtb_pkg::ACC_W'($signed(abtb_pkg::COORD_MIN));

	logic signed [abtb_pkg::SUM_W-1:0] span_s3 [3];
	logic signed [abtb_pkg::ACC_W-1:0] ctr_s3  [3];

	logic signed [abtb_pkg::ACC_W-1:0] lo_sum [3];
	logic signed [abtb_pkg::ACC_W-1:0] hi_sum [3];
	logic [abtb_pkg::COORD_W:0]        lo_res [3];
	logic [abtb_pkg::COORD_W:0]        hi_res [3];
	logic                              any_sat;

	// Round to the nearest coordinate step (the half step is already in the sum),
	// then clamp; the top bit of the result flags a clamp.
	function automatic logic [abtb_pkg::COORD_W:0] round_sat(
		input logic signed [abtb_pkg::ACC_W-1:0] v
	);
		logic signed [abtb_pkg::ACC_W-1:0] s;
		s = v >>> abtb_pkg::RFRAC;
		if (s > LIM_HI) begin
			return {1'b1, abtb_pkg::COORD_MAX};
		end else if (s < LIM_LO) begin
			return {1'b1, abtb_pkg::COORD_MIN};
		end
		return {1'b0, s[abtb_pkg::COORD_W-1:0]};
	endfunction

	// Stage 3: half span per output axis and the scaled centre plus half a step.
	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			for (int j = 0; j < 3; j++) begin
				span_s3[j] <= abtb_pkg::SUM_W'(prod_s2[0][j]) + abtb_pkg::SUM_W'(prod_s2[1][j])
					+ abtb_pkg::SUM_W'(prod_s2[2][j]);
				ctr_s3[j] <= (abtb_pkg::ACC_W'(mid_s2[j]) <<< abtb_pkg::COEFF_FRAC) + HALF_STEP;
			end
		end
	end

	// Both bounds of each axis, rounded and clamped.
	always_comb begin
		any_sat = 1'b0;
		for (int j = 0; j < 3; j++) begin
			lo_sum[j] = ctr_s3[j] - abtb_pkg::ACC_W'(span_s3[j]);
			hi_sum[j] = ctr_s3[j] + abtb_pkg::ACC_W'(span_s3[j]);
			lo_res[j] = round_sat(lo_sum[j]);
			hi_res[j] = round_sat(hi_sum[j]);
			any_sat   = any_sat | lo_res[j][abtb_pkg::COORD_W] | hi_res[j][abtb_pkg::COORD_W];
		end
	end

	// Stage 4: output word register.
	always_ff @(posedge clk) begin
		if (en.en_s4) begin
			for (int j = 0; j < 3; j++) begin
				new_min_s4[j] <= lo_res[j][abtb_pkg::COORD_W-1:0];
				new_max_s4[j] <= hi_res[j][abtb_pkg::COORD_W-1:0];
			end
			sat_s4 <= any_sat;
		end
	end

endmodule

// ===== hw/rtl/aabb_transform_bounds_unit.sv =====
`timescale 1ns / 1ps
// Top level of the transformed axis-aligned bounding box unit.
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+----------------------------------
//  in      | input     | in_valid / in_stall    | min_x..z, max_x..z
//  out     | output    | out_valid / out_stall  | new_min_x..z, new_max_x..z, saturated
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Four register stages: extents, products, sums, rounded output. One word enters per cycle
// while in_stall is low; the nine parallel multipliers set the stage depth.
// Reset clears the stage valid bits and loads the identity map into the coefficients.
// A stall holds the output word; stages behind it keep filling empty slots, so in_stall
// rises only when every stage is full.
module aabb_transform_bounds_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  abtb_pkg::coord_t                 min_x,
	input  abtb_pkg::coord_t                 min_y,
	input  abtb_pkg::coord_t                 min_z,
	input  abtb_pkg::coord_t                 max_x,
	input  abtb_pkg::coord_t                 max_y,
	input  abtb_pkg::coord_t                 max_z,
	output logic                             out_valid,
	input  logic                             out_stall,
	output abtb_pkg::coord_t                 new_min_x,
	output abtb_pkg::coord_t                 new_min_y,
	output abtb_pkg::coord_t                 new_min_z,
	output abtb_pkg::coord_t                 new_max_x,
	output abtb_pkg::coord_t                 new_max_y,
	output abtb_pkg::coord_t                 new_max_z,
	output logic                             saturated,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [abtb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [abtb_pkg::CFG_DATA_W-1:0]  cfg_data
);

	abtb_pkg::stage_en_t  en;
	abtb_pkg::mag_mat_t   mag;
	abtb_pkg::coord_arr_t box_min;
	abtb_pkg::coord_arr_t box_max;
	abtb_pkg::ext_arr_t   mid_s2;
	abtb_pkg::prod_mat_t  prod_s2;
	abtb_pkg::coord_arr_t new_min_s4;
	abtb_pkg::coord_arr_t new_max_s4;
	logic                 sat_s4;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;

	// A stage loads when it is empty or the stage after it loads too.
	always_comb begin
		en.en_s4 = !valid_s4 || !out_stall;
		en.en_s3 = !valid_s3 || en.en_s4;
		en.en_s2 = !valid_s2 || en.en_s3;
		en.en_s1 = !valid_s1 || en.en_s2;
	end

	assign in_stall = !en.en_s1;

	// Valid bits travel with the words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en.en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en.en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en.en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en.en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// Gather the input corners by axis.
	always_comb begin
		box_min[0] = min_x;
		box_min[1] = min_y;
		box_min[2] = min_z;
		box_max[0] = max_x;
		box_max[1] = max_y;
		box_max[2] = max_z;
	end

	abtb_coeff_regs u_coeff_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mag       (mag)
	);

	abtb_extent_mult u_extent_mult (
		.clk     (clk),
		.en      (en),
		.box_min (box_min),
		.box_max (box_max),
		.mag     (mag),
		.mid_s2  (mid_s2),
		.prod_s2 (prod_s2)
	);

	abtb_bound_round u_bound_round (
		.clk        (clk),
		.en         (en),
		.mid_s2     (mid_s2),
		.prod_s2    (prod_s2),
		.new_min_s4 (new_min_s4),
		.new_max_s4 (new_max_s4),
		.sat_s4     (sat_s4)
	);

	assign out_valid = valid_s4;
	assign new_min_x = new_min_s4[0];
	assign new_min_y = new_min_s4[1];
	assign new_min_z = new_min_s4[2];
	assign new_max_x = new_max_s4[0];
	assign new_max_y = new_max_s4[1];
	assign new_max_z = new_max_s4[2];
	assign saturated = sat_s4;

endmodule

// ===== sim/aabb_transform_bounds_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts and compares every result word of the transformed bounding box unit.
module aabb_transform_bounds_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  abtb_pkg::coord_t                 min_x,
	input  abtb_pkg::coord_t                 min_y,
	input  abtb_pkg::coord_t                 min_z,
	input  abtb_pkg::coord_t                 max_x,
	input  abtb_pkg::coord_t                 max_y,
	input  abtb_pkg::coord_t                 max_z,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  abtb_pkg::coord_t                 new_min_x,
	input  abtb_pkg::coord_t                 new_min_y,
	input  abtb_pkg::coord_t                 new_min_z,
	input  abtb_pkg::coord_t                 new_max_x,
	input  abtb_pkg::coord_t                 new_max_y,
	input  abtb_pkg::coord_t                 new_max_z,
	input  logic                             saturated,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [abtb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [abtb_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                               mismatch_count,
	output int                               pending_count
);

	localparam int COORD_W    = abtb_pkg::COORD_W;
	localparam int COEFF_W    = abtb_pkg::COEFF_W;
	localparam int CFG_DATA_W = abtb_pkg::CFG_DATA_W;
	localparam int REPORT_MAX = 10;

	// Ends of the coordinate range and the fixed-point steps of the scaled sums.
	localparam longint COORD_HI  = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
	localparam longint COORD_LO  = -COORD_HI - 64'sd1;
	localparam longint FRAC_ONE  = 64'sd1 <<< abtb_pkg::RFRAC;
	localparam longint FRAC_MASK = FRAC_ONE - 64'sd1;
	localparam longint HALF_STEP = 64'sd1 <<< abtb_pkg::COEFF_FRAC;

	typedef struct packed {
		abtb_pkg::coord_t lo_x;
		abtb_pkg::coord_t lo_y;
		abtb_pkg::coord_t lo_z;
		abtb_pkg::coord_t hi_x;
		abtb_pkg::coord_t hi_y;
		abtb_pkg::coord_t hi_z;
		logic             sat;
	} bounds_t;

	// Coefficient rows, indexed by source axis, as last written to the block.
	logic [CFG_DATA_W-1:0] coeff_rows [3];
	bounds_t               bounds_q [$];
	bounds_t               got_bounds;
	bounds_t               want_bounds;

	// Fraction bits below the coordinate step, always non-negative.
	function automatic longint frac_part(input longint v);
		return v & FRAC_MASK;
	endfunction

	// Whole coordinate steps, rounded toward minus infinity.
	function automatic longint whole_part(input longint v);
		return (v - frac_part(v)) / FRAC_ONE;
	endfunction

	// Rounds a split bound to the nearest step, ties upward, then clamps.
	// The top bit of the return value tells whether the bound was clamped.
	function automatic logic [COORD_W:0] round_clamp(input longint ip, input longint rp);
		longint v;
		logic   clamped;
		clamped = 1'b0;
		v = ip + whole_part(rp) + ((frac_part(rp) >= HALF_STEP) ? 64'sd1 : 64'sd0);
		if (v > COORD_HI) begin
			v = COORD_HI;
			clamped = 1'b1;
		end
		if (v < COORD_LO) begin
			v = COORD_LO;
			clamped = 1'b1;
		end
		return {clamped, v[COORD_W-1:0]};
	endfunction

	// Enclosing box of the box mapped about its own center by the current rows.
	function automatic bounds_t transform_bounds(
		input abtb_pkg::coord_t ax, input abtb_pkg::coord_t ay, input abtb_pkg::coord_t az,
		input abtb_pkg::coord_t bx, input abtb_pkg::coord_t by, input abtb_pkg::coord_t bz
	);
		longint                     lo_v [3];
		longint                     ext [3];
		longint                     ext_w [3];
		longint                     ext_f [3];
		longint                     odd;
		longint                     base_i;
		longint                     base_r;
		longint                     sum_w;
		longint                     sum_f;
		longint                     mag;
		logic signed [COEFF_W-1:0]  coeff;
		logic [COORD_W:0]           lo_r [3];
		logic [COORD_W:0]           hi_r [3];
		bounds_t                    b;
		int                         i;
		int                         j;
		lo_v[0] = ax;
		lo_v[1] = ay;
		lo_v[2] = az;
		ext[0] = longint'(bx) - lo_v[0];
		ext[1] = longint'(by) - lo_v[1];
		ext[2] = longint'(bz) - lo_v[2];
		for (i = 0; i < 3; i++) begin
			ext_w[i] = whole_part(ext[i]);
			ext_f[i] = frac_part(ext[i]);
		end
		for (j = 0; j < 3; j++) begin
			// Center is min plus half the extent; an odd extent leaves half a step.
			odd = ext[j] & 64'sd1;
			base_i = lo_v[j] + (ext[j] - odd) / 2;
			base_r = (odd != 0) ? HALF_STEP : 64'sd0;
			sum_w = 0;
			sum_f = 0;
			for (i = 0; i < 3; i++) begin
				coeff = coeff_rows[i][j*COEFF_W +: COEFF_W];
				mag = coeff;
				if (mag < 0)
					mag = -mag;
				sum_w += mag * ext_w[i];
				sum_f += mag * ext_f[i];
			end
			lo_r[j] = round_clamp(base_i - sum_w, base_r - sum_f);
			hi_r[j] = round_clamp(base_i + sum_w, base_r + sum_f);
		end
		b.lo_x = lo_r[0][COORD_W-1:0];
		b.lo_y = lo_r[1][COORD_W-1:0];
		b.lo_z = lo_r[2][COORD_W-1:0];
		b.hi_x = hi_r[0][COORD_W-1:0];
		b.hi_y = hi_r[1][COORD_W-1:0];
		b.hi_z = hi_r[2][COORD_W-1:0];
		b.sat  = lo_r[0][COORD_W] | lo_r[1][COORD_W] | lo_r[2][COORD_W] |
			hi_r[0][COORD_W] | hi_r[1][COORD_W] | hi_r[2][COORD_W];
		return b;
	endfunction

	// Watch all three channels; input words are predicted before results are compared.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++)
				coeff_rows[k] = CFG_DATA_W'(abtb_pkg::COEFF_ONE) << (k * COEFF_W);
			bounds_q.delete();
			mismatch_count = 0;
			pending_count = 0;
		end else begin
			if (in_valid && !in_stall)
				bounds_q.push_back(transform_bounds(min_x, min_y, min_z, max_x, max_y, max_z));

			if (out_valid && !out_stall) begin
				got_bounds = '{new_min_x, new_min_y, new_min_z,
					new_max_x, new_max_y, new_max_z, saturated};
				if (bounds_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("%0t: result word with none expected: min %h %h %h max %h %h %h sat %b",
							$realtime, new_min_x, new_min_y, new_min_z,
							new_max_x, new_max_y, new_max_z, saturated);
				end else begin
					want_bounds = bounds_q.pop_front();
					if (got_bounds.lo_x !== want_bounds.lo_x ||
						got_bounds.lo_y !== want_bounds.lo_y ||
						got_bounds.lo_z !== want_bounds.lo_z ||
						got_bounds.hi_x !== want_bounds.hi_x ||
						got_bounds.hi_y !== want_bounds.hi_y ||
						got_bounds.hi_z !== want_bounds.hi_z ||
						got_bounds.sat !== want_bounds.sat) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_MAX) begin
							$display("%0t: mismatch, expected min %h %h %h max %h %h %h sat %b",
								$realtime, want_bounds.lo_x, want_bounds.lo_y, want_bounds.lo_z,
								want_bounds.hi_x, want_bounds.hi_y, want_bounds.hi_z,
								want_bounds.sat);
							$display("%0t:           got      min %h %h %h max %h %h %h sat %b",
								$realtime, got_bounds.lo_x, got_bounds.lo_y, got_bounds.lo_z,
								got_bounds.hi_x, got_bounds.hi_y, got_bounds.hi_z,
								got_bounds.sat);
						end
					end
				end
			end

			// Indexes past the last row are ignored by the block.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					abtb_pkg::REG_FROM_X: coeff_rows[0] = cfg_data;
					abtb_pkg::REG_FROM_Y: coeff_rows[1] = cfg_data;
					abtb_pkg::REG_FROM_Z: coeff_rows[2] = cfg_data;
					default: ;
				endcase
			end

			pending_count = bounds_q.size();
		end
	end

endmodule

// ===== sim/tb_aabb_transform_bounds_unit.sv =====
`timescale 1ns / 1ps
// Testbench top: reset, coefficient phases, box stimulus with random idling, and the verdict.
module tb_aabb_transform_bounds_unit;

	// Package widths, types and coordinate limits used here.
	typedef abtb_pkg::coord_t coord_t;
	localparam int CFG_IDX_W  = abtb_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = abtb_pkg::CFG_DATA_W;
	localparam int COEFF_W    = abtb_pkg::COEFF_W;
	localparam logic [abtb_pkg::COORD_W-1:0] COORD_MAX = abtb_pkg::COORD_MAX;
	localparam logic [abtb_pkg::COORD_W-1:0] COORD_MIN = abtb_pkg::COORD_MIN;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 5;
	localparam int LIMIT_CYCLES = 600000;
	localparam int DRAIN_CYCLES = 16;

	// Index past the three coefficient rows; writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

	// Coefficient styles for random rows.
	localparam int STYLE_FULL  = 0;
	localparam int STYLE_UNIT  = 1;
	localparam int STYLE_EDGE  = 2;
	localparam int STYLE_MIXED = 3;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	coord_t                min_x, min_y, min_z, max_x, max_y, max_z;
	logic                  out_valid;
	logic                  out_stall;
	coord_t                new_min_x, new_min_y, new_min_z, new_max_x, new_max_y, new_max_z;
	logic                  saturated;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatch_count;
	int                    pending_count;
	int                    cycle_count = 0;
	bit                    calm = 1'b0;

	aabb_transform_bounds_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.min_x     (min_x),
		.min_y     (min_y),
		.min_z     (min_z),
		.max_x     (max_x),
		.max_y     (max_y),
		.max_z     (max_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.new_min_x (new_min_x),
		.new_min_y (new_min_y),
		.new_min_z (new_min_z),
		.new_max_x (new_max_x),
		.new_max_y (new_max_y),
		.new_max_z (new_max_z),
		.saturated (saturated),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	aabb_transform_bounds_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.min_x          (min_x),
		.min_y          (min_y),
		.min_z          (min_z),
		.max_x          (max_x),
		.max_y          (max_y),
		.max_z          (max_z),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.new_min_x      (new_min_x),
		.new_min_y      (new_min_y),
		.new_min_z      (new_min_z),
		.new_max_x      (new_max_x),
		.new_max_y      (new_max_y),
		.new_max_z      (new_max_z),
		.saturated      (saturated),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	always #(CLK_HALF) clk = ~clk;

	// Hard stop if the run hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Idle length: mostly short, now and then a long one.
	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	// Receiver stalls at random, except during a calm phase.
	initial begin
		int stall_left;
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else begin
				out_stall = 1'b0;
				if (!calm && $urandom_range(0, 99) < 20)
					stall_left = pick_gap();
			end
		end
	end

	// Clips a wide value into the coordinate range.
	function automatic coord_t clip(input longint v);
		if (v > longint'(COORD_MAX))
			return COORD_MAX;
		if (v < -longint'(COORD_MAX) - 1)
			return COORD_MIN;
		return coord_t'(v);
	endfunction

	function automatic coord_t pick_extreme();
		case ($urandom_range(0, 4))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2: return '0;
			3: return '1;
			default: return coord_t'(1);
		endcase
	endfunction

	// One coefficient row of three fields in the requested style.
	function automatic logic [CFG_DATA_W-1:0] random_row(input int style);
		logic [CFG_DATA_W-1:0] row;
		logic [COEFF_W-1:0]    field;
		int                    s;
		row = '0;
		for (int j = 0; j < 3; j++) begin
			s = (style == STYLE_MIXED) ? $urandom_range(STYLE_FULL, STYLE_EDGE) : style;
			case (s)
				STYLE_FULL: field = COEFF_W'($urandom);
				STYLE_UNIT: field = COEFF_W'(int'($urandom_range(0, 8192)) - 4096);
				default: begin
					case ($urandom_range(0, 4))
						0: field = COEFF_W'(1);
						1: field = '1;
						2: field = '0;
						3: field = {1'b1, {(COEFF_W-1){1'b0}}};
						default: field = {1'b0, {(COEFF_W-1){1'b1}}};
					endcase
				end
			endcase
			row[j*COEFF_W +: COEFF_W] = field;
		end
		return row;
	endfunction

	// Sends one box word and holds it until accepted; returns at a falling edge.
	task automatic send_box(input coord_t ax, input coord_t ay, input coord_t az,
		input coord_t bx, input coord_t by, input coord_t bz);
		int gap;
		gap = (!calm && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		min_x = ax;
		min_y = ay;
		min_z = az;
		max_x = bx;
		max_y = by;
		max_z = bz;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_cube(input coord_t lo, input coord_t hi);
		send_box(lo, lo, lo, hi, hi, hi);
	endtask

	// Random box: well-formed boxes of every scale, plus noise, inverted,
	// degenerate, tiny and extreme corners.
	task automatic send_random_box();
		longint lo [3];
		longint hi [3];
		longint c;
		longint h;
		longint t;
		int     mode;
		mode = $urandom_range(0, 9);
		for (int i = 0; i < 3; i++) begin
			c = longint'($signed($urandom)) >>> $urandom_range(0, 20);
			h = longint'($urandom >> $urandom_range(1, 31));
			lo[i] = c - h;
			hi[i] = c + h + $urandom_range(0, 1);
			case (mode)
				0, 1: begin
					lo[i] = longint'($signed($urandom));
					hi[i] = longint'($signed($urandom));
				end
				6: begin
					t = lo[i];
					lo[i] = hi[i];
					hi[i] = t;
				end
				7: begin
					lo[i] = int'($urandom_range(0, 16)) - 8;
					hi[i] = int'($urandom_range(0, 16)) - 8;
				end
				8: begin
					lo[i] = longint'(pick_extreme());
					hi[i] = longint'(pick_extreme());
				end
				9: hi[i] = lo[i];
				default: ;
			endcase
		end
		send_box(clip(lo[0]), clip(lo[1]), clip(lo[2]), clip(hi[0]), clip(hi[1]), clip(hi[2]));
	endtask

	// Lets every word in flight come out before the coefficients change.
	task automatic wait_idle();
		in_valid = 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Writes all three rows back to back; sometimes also the unused index.
	task automatic set_rows(input logic [CFG_DATA_W-1:0] row_x,
		input logic [CFG_DATA_W-1:0] row_y, input logic [CFG_DATA_W-1:0] row_z);
		logic [CFG_IDX_W-1:0]  idx [4];
		logic [CFG_DATA_W-1:0] val [4];
		int                    n;
		idx[0] = abtb_pkg::REG_FROM_X;
		idx[1] = abtb_pkg::REG_FROM_Y;
		idx[2] = abtb_pkg::REG_FROM_Z;
		idx[3] = CFG_IDX_UNUSED;
		val[0] = row_x;
		val[1] = row_y;
		val[2] = row_z;
		val[3] = random_row(STYLE_FULL);
		n = ($urandom_range(0, 1) == 1) ? 4 : 3;
		for (int k = 0; k < n; k++) begin
			cfg_index = idx[k];
			cfg_data = val[k];
			cfg_valid = 1'b1;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			@(negedge clk);
		end
		cfg_valid = 1'b0;
	endtask

	task automatic run_random(input int n);
		repeat (n) send_random_box();
	endtask

	task automatic random_phase(input int style, input int n);
		wait_idle();
		set_rows(random_row(style), random_row(style), random_row(style));
		run_random(n);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		min_x = '0;
		min_y = '0;
		min_z = '0;
		max_x = '0;
		max_y = '0;
		max_z = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Identity map from reset: extremes, inverted and odd-extent boxes.
		send_cube('0, '0);
		send_cube('0, coord_t'(32'h0001_0000));
		send_cube(COORD_MIN, COORD_MAX);
		send_cube(COORD_MAX, COORD_MIN);
		send_cube(COORD_MIN, COORD_MIN);
		send_cube(COORD_MAX, COORD_MAX);
		send_box(coord_t'(0), coord_t'(-1), coord_t'(-3), coord_t'(1), coord_t'(0), coord_t'(2));
		send_box(coord_t'(-5), coord_t'(7), COORD_MIN, coord_t'(5), coord_t'(9), '0);
		send_box(COORD_MAX, '0, COORD_MIN, '0, COORD_MAX, COORD_MAX);
		run_random(120);

		// Most negative coefficients everywhere: saturation in both directions.
		wait_idle();
		set_rows({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
		send_cube(COORD_MIN, COORD_MAX);
		send_cube(COORD_MAX, COORD_MIN);
		send_cube(coord_t'(0), coord_t'(1));
		send_cube(coord_t'(0), coord_t'(3));
		send_cube(coord_t'(-1), coord_t'(-1));
		send_cube('0, coord_t'(32'h0001_0000));
		run_random(120);

		// Most positive coefficients, with no idling on either side.
		wait_idle();
		calm = 1'b1;
		set_rows({3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}});
		run_random(120);
		calm = 1'b0;

		// Zero map: every box collapses onto its center.
		wait_idle();
		set_rows('0, '0, '0);
		run_random(110);

		// Smallest coefficient steps: rounding ties and half steps.
		wait_idle();
		set_rows({16'h0001, 16'hffff, 16'h0001}, {16'hffff, 16'h0001, 16'h0000},
			{16'h0001, 16'h0000, 16'hffff});
		send_cube(coord_t'(0), coord_t'(1));
		send_cube(coord_t'(-1), coord_t'(0));
		send_cube(coord_t'(0), coord_t'(8192));
		send_cube(coord_t'(1), coord_t'(2));
		send_box('0, '0, '0, coord_t'(8191), coord_t'(8192), coord_t'(8193));
		run_random(110);

		random_phase(STYLE_EDGE, 110);
		random_phase(STYLE_UNIT, 110);
		random_phase(STYLE_FULL, 110);
		random_phase(STYLE_MIXED, 110);
		random_phase(STYLE_MIXED, 110);

		wait_idle();
		if (mismatch_count == 0 && pending_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
